// ===== design/arh_pkg.sv =====
package arh_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned ValueWidth = 32;

  typedef enum logic [2:0] {
    REQ_START   = 3'd0,
    REQ_RANGE   = 3'd1,
    REQ_FINISH  = 3'd2,
    REQ_BIN     = 3'd3,
    REQ_READ    = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    CFG_BINS = 2'd0,
    CFG_LOW  = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [7:0]         bin_index;
  } req_t;

  typedef struct packed {
    logic [31:0]        bin_count;
    logic [31:0]        total_count;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic               binned;
  } rsp_t;

  localparam logic signed [31:0] OneQ = 32'sd65536;

  // round(mid*k/10) for k of 9 or 11, ties away from zero, saturated to 32 bits;
  // mid*9/10 = mid - mid/10 and mid*11/10 = mid + mid/10, so only a 32-bit
  // divide by ten is needed, done by reciprocal multiplication
  function automatic logic signed [31:0] scale_tenths(input logic signed [31:0] mid,
                                                      input logic [3:0] k);
    logic [31:0] mag;
    logic [31:0] a;
    logic [63:0] prod;
    logic [31:0] t;
    logic [31:0] r;
    logic [32:0] s;
    mag  = mid[31] ? 32'(-mid) : 32'(mid);
    a    = mag + 32'd4;
    prod = {32'd0, a} * 64'h0000_0000_CCCC_CCCD;
    t    = {3'd0, prod[63:35]};
    r    = a - ({t[28:0], 3'b000} + {t[30:0], 1'b0});
    if (k == 4'd11) s = {1'b0, mag} + {1'b0, t} + ((r == 32'd9) ? 33'd1 : 33'd0);
    else            s = {1'b0, mag} - {1'b0, t};
    if (!mid[31]) begin
      if (s > 33'h0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      return $signed(s[31:0]);
    end
    if (s > 33'h0_8000_0000) return 32'sh8000_0000;
    return $signed(32'd0 - s[31:0]);
  endfunction

endpackage

// ===== design/auto_range_histogram_core.sv =====
// Channel    | Signals                                | Timing
// request    | start, busy, req (req_t)               | transfer when start & !busy
// result     | done, rsp (rsp_t)                      | one-cycle strobe, no backpressure
// config     | cfg_we, cfg_index, cfg_data            | written on any edge with cfg_we
//
// Bin samples inside the range and below the high bound go from transfer to
// result through a 45-step bit-serial divider that forms the bin number, then
// the bin RAM is read and written back.
// Other requests skip the divider; reads use the same RAM port. A new request waits until busy drops.
// Reset is synchronous; bin valid flags clear at once, so no clearing pass.
// Results cannot be stalled; busy drops in the result strobe cycle, so the next
// request can transfer at the edge that takes the result.
module auto_range_histogram_core
  import arh_pkg::*;
#(
  parameter int unsigned MAX_BINS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  req_t                        req,
  output logic                        done,
  output rsp_t                        rsp,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int unsigned AddrW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NW    = AddrW + 1;

  state_e state, state_next;

  logic [8:0]         bins_in_use;
  logic signed [31:0] low_limit, high_limit;
  logic signed [31:0] working_low, working_high;
  logic [31:0]        samples_binned;
  logic [MAX_BINS-1:0] bin_valid;

  logic [2:0]         cur_type;
  logic [AddrW-1:0]   addr;
  logic               addr_ok;
  logic               hit;
  logic [31:0]        rsp_count;
  logic               rsp_hit;

  logic [NW-1:0]      n_eff;
  logic               div_go, div_done;
  logic [44:0]        div_num, div_quot;
  logic [32:0]        div_den;

  logic               ram_we;
  logic [31:0]        ram_rdata, ram_wdata;

  // clamp configured bin count
  always_comb begin
    if (bins_in_use == 9'd0)
      n_eff = NW'(1);
    else if ({23'd0, bins_in_use} > 32'(MAX_BINS))
      n_eff = NW'(MAX_BINS);
    else
      n_eff = NW'(bins_in_use);
  end

  logic signed [32:0] diff_v, diff_r;
  logic               in_range;
  assign diff_v   = 33'(req.value) - 33'(working_low);
  assign diff_r   = 33'(working_high) - 33'(working_low);
  assign in_range = (req.value >= working_low) && (req.value <= working_high);
  assign div_num  = 45'(diff_v[32:0]) * 45'(n_eff);
  assign div_den  = diff_r;

  arh_divider u_div (
    .clk (clk), .rst (rst), .go (div_go), .num (div_num), .den (div_den),
    .done(div_done), .quot(div_quot)
  );

  arh_bin_ram #(.Depth(MAX_BINS), .AddrW(AddrW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(addr), .wdata(ram_wdata),
    .raddr(addr), .rdata(ram_rdata)
  );

  assign busy = (state != ST_IDLE);

  // read data is valid in ST_DONE; write the new count back there
  logic [31:0] old_count;
  assign old_count = bin_valid[addr] ? ram_rdata : 32'd0;
  assign ram_wdata = (old_count == 32'hFFFF_FFFF) ? old_count : old_count + 32'd1;
  assign ram_we    = (state == ST_DONE) && hit;

  logic take;
  assign take = start && !busy;

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    unique case (state)
      ST_IDLE: if (take) begin
        if (req.req_type == REQ_BIN && in_range && req.value != working_high) begin
          div_go     = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_MEM;
        end
      end
      ST_DIV:  if (div_done) state_next = ST_MEM;
      ST_MEM:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= 9'd256;
      low_limit   <= 32'sh7FFF_FFFF;
      high_limit  <= 32'sh8000_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BINS: bins_in_use <= cfg_data[8:0];
        CFG_LOW:  low_limit   <= cfg_data;
        CFG_HIGH: high_limit  <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      working_low    <= 32'sh7FFF_FFFF;
      working_high   <= 32'sh8000_0000;
      samples_binned <= '0;
      bin_valid      <= '0;
      done           <= 1'b0;
      hit            <= 1'b0;
    end else begin
      done <= 1'b0;
      if (take) begin
        cur_type <= req.req_type;
        hit <= 1'b0;
        addr_ok <= 1'b1;
        case (req.req_type)
          REQ_START: begin
            bin_valid      <= '0;
            working_low    <= low_limit;
            working_high   <= high_limit;
            samples_binned <= '0;
          end
          REQ_RANGE: begin
            if (req.value < working_low)  working_low  <= req.value;
            if (req.value > working_high) working_high <= req.value;
          end
          REQ_FINISH: begin
            if (working_low == working_high) begin
              if (working_low == 32'sd0) begin
                working_low  <= -OneQ;
                working_high <= OneQ;
              end else begin
                working_low  <= scale_tenths(working_low, 4'd9);
                working_high <= scale_tenths(working_low, 4'd11);
              end
            end
          end
          REQ_BIN: begin
            hit  <= in_range;
            addr <= AddrW'(n_eff - NW'(1));
          end
          REQ_READ: begin
            addr    <= AddrW'(req.bin_index);
            addr_ok <= ({24'd0, req.bin_index} < 32'(MAX_BINS));
          end
          default: ;
        endcase
      end
      if (state == ST_DIV && div_done) begin
        if (div_quot >= 45'(n_eff)) addr <= AddrW'(n_eff - NW'(1));
        else                        addr <= AddrW'(div_quot);
      end
      if (state == ST_DONE) begin
        if (hit) begin
          bin_valid[addr] <= 1'b1;
          if (samples_binned != 32'hFFFF_FFFF) samples_binned <= samples_binned + 32'd1;
        end
        done    <= 1'b1;
        rsp_hit <= hit;
        if (cur_type == REQ_READ)
          rsp_count <= (addr_ok && bin_valid[addr]) ? ram_rdata : 32'd0;
        else if (hit)
          rsp_count <= ram_wdata;
        else
          rsp_count <= 32'd0;
      end
    end
  end

  assign rsp = '{bin_count:   rsp_count,
                 total_count: samples_binned,
                 low_bound:   working_low,
                 high_bound:  working_high,
                 binned:      rsp_hit};

endmodule

// ===== design/arh_divider.sv =====
module arh_divider
  import arh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [44:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [44:0] quot
);

  logic [5:0]  step;
  logic        running;
  logic [45:0] rem;
  logic [44:0] q;
  logic [45:0] trial;

  assign trial = {rem[44:0], q[44]};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= 6'd0;
        rem     <= '0;
        q       <= num;
      end else if (running) begin
        // one quotient bit per cycle, restoring
        if (trial >= {13'd0, den}) begin
          rem <= trial - {13'd0, den};
          q   <= {q[43:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[43:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'd44) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/arh_bin_ram.sv =====
module arh_bin_ram
  import arh_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [31:0]      wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [31:0]      rdata
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import arh_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  auto_range_histogram_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the histogram state, kept in step with accepted transfers.
  logic [31:0]        hist_count [256];
  logic               hist_valid [256];
  logic signed [63:0] range_lo, range_hi;
  logic [31:0]        binned_total;
  logic [8:0]         nbins_reg;
  logic signed [63:0] cfg_lo, cfg_hi;

  rsp_t   pending_rsp [$];
  int     fail_count = 0;
  int     rsp_count = 0;
  int     req_count = 0;
  longint cycle_count = 0;

  localparam longint CycleLimit = 2_000_000;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [63:0] round_tenths(logic signed [63:0] mid, int k);
    logic signed [63:0] p, q;
    p = mid * k;
    q = (p < 0) ? -((-p + 5) / 10) : ((p + 5) / 10);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Advance the shadow state by one request and return the result it causes.
  function automatic rsp_t histogram_step(req_t r);
    rsp_t               o;
    logic signed [63:0] v, mid;
    logic [63:0]        num, den;
    int unsigned        n, b;
    o = '0;
    v = r.value;
    n = nbins_reg;
    if (n == 0) n = 1;
    if (n > 256) n = 256;
    case (r.req_type)
      REQ_START: begin
        for (int i = 0; i < 256; i++) hist_valid[i] = 1'b0;
        range_lo = cfg_lo;
        range_hi = cfg_hi;
        binned_total = '0;
      end
      REQ_RANGE: begin
        if (v < range_lo) range_lo = v;
        if (v > range_hi) range_hi = v;
      end
      REQ_FINISH: begin
        if (range_lo == range_hi) begin
          if (range_lo == 0) begin
            range_lo = -65536;
            range_hi = 65536;
          end else begin
            mid = range_lo;
            range_lo = round_tenths(mid, 9);
            range_hi = round_tenths(mid, 11);
          end
        end
      end
      REQ_BIN: begin
        if (v >= range_lo && v <= range_hi) begin
          if (v == range_hi) b = n - 1;
          else begin
            num = 64'(v - range_lo) * 64'(n);
            den = 64'(range_hi - range_lo);
            b = int'(num / den);
            if (b >= n) b = n - 1;
          end
          if (!hist_valid[b]) hist_count[b] = 32'd1;
          else if (hist_count[b] != '1) hist_count[b] = hist_count[b] + 1;
          hist_valid[b] = 1'b1;
          if (binned_total != '1) binned_total = binned_total + 1;
          o.bin_count = hist_count[b];
          o.binned = 1'b1;
        end
      end
      REQ_READ: begin
        if (hist_valid[r.bin_index]) o.bin_count = hist_count[r.bin_index];
      end
      default: ;
    endcase
    o.total_count = binned_total;
    o.low_bound = range_lo[31:0];
    o.high_bound = range_hi[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
    fail_count++;
  endtask

  // Compare every result strobe against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", rsp.bin_count, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.bin_count !== want.bin_count)
          report_mismatch("bin_count", rsp.bin_count, want.bin_count);
        if (rsp.total_count !== want.total_count)
          report_mismatch("total_count", rsp.total_count, want.total_count);
        if (rsp.low_bound !== want.low_bound)
          report_mismatch("low_bound", rsp.low_bound, want.low_bound);
        if (rsp.high_bound !== want.high_bound)
          report_mismatch("high_bound", rsp.high_bound, want.high_bound);
        if (rsp.binned !== want.binned)
          report_mismatch("binned", 32'(rsp.binned), 32'(want.binned));
      end
    end
  end

  // Sender burst shaping: a random gap, then a burst of random length.
  int burst_left = 0;

  task automatic send_request(logic [2:0] kind, logic [31:0] val, logic [7:0] idx);
    req_t r;
    int   gap;
    // Step past the edge of the previous transfer before raising start again.
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    r.req_type = kind;
    r.value = val;
    r.bin_index = idx;
    start <= 1'b1;
    req <= r;
    // Hold start until the transfer; busy is sampled as it was before the edge.
    do @(posedge clk); while (busy);
    pending_rsp.insert(pending_rsp.size(), histogram_step(r));
    req_count++;
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write a register while idle and mirror it.
  task automatic write_reg(cfg_e which, logic [31:0] data);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_BINS: nbins_reg = data[8:0];
      CFG_LOW:  cfg_lo = $signed(data);
      default:  cfg_hi = $signed(data);
    endcase
  endtask

  function automatic logic [31:0] pick_value(logic signed [31:0] lo, logic signed [31:0] hi);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    if (sel == 1) return lo;
    if (sel == 2) return hi;
    if (hi <= lo) return $urandom();
    return 32'(lo + ($urandom() % (longint'(hi) - longint'(lo) + 1)));
  endfunction

  task automatic test_directed();
    write_reg(CFG_BINS, 32'd4);
    write_reg(CFG_LOW, 32'h0000_0000);
    write_reg(CFG_HIGH, 32'h0004_0000);
    send_request(REQ_START, '0, '0);
    send_request(REQ_BIN, 32'h0000_0000, '0);
    send_request(REQ_BIN, 32'h0004_0000, '0);
    send_request(REQ_BIN, 32'h0001_8000, '0);
    send_request(REQ_BIN, 32'h8000_0000, '0);
    send_request(REQ_BIN, 32'h7FFF_FFFF, '0);
    send_request(REQ_READ, '0, 8'd3);
    send_request(REQ_READ, '0, 8'd255);
    send_request(REQ_RANGE, 32'hFFFF_0000, '0);
    send_request(3'd5, '1, '1);
    send_request(3'd7, '0, '0);
    // Automatic range: empty, then degenerate at zero, positive, negative.
    write_reg(CFG_LOW, 32'h7FFF_FFFF);
    write_reg(CFG_HIGH, 32'h8000_0000);
    send_request(REQ_START, '0, '0);
    send_request(REQ_FINISH, '0, '0);
    send_request(REQ_BIN, 32'h7FFF_FFFF, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_RANGE, 32'h0000_0000, '0);
    send_request(REQ_FINISH, '0, '0);
    send_request(REQ_BIN, 32'hFFFF_8000, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_RANGE, 32'h7FFF_FFFF, '0);
    send_request(REQ_FINISH, '0, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_RANGE, 32'hFFF0_0000, '0);
    send_request(REQ_FINISH, '0, '0);
    send_request(REQ_BIN, 32'hFFF0_0000, '0);
  endtask

  task automatic test_random_sessions(int total);
    int sent = 0;
    int roll, nsamp;
    logic signed [31:0] a, c;
    while (sent < total) begin
      roll = $urandom_range(0, 5);
      case (roll)
        0: write_reg(CFG_BINS, 32'($urandom_range(0, 511)));
        1: write_reg(CFG_BINS, ($urandom_range(0, 1) == 0) ? 32'd1 : 32'd256);
        default: ;
      endcase
      a = $urandom();
      c = $urandom();
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_LOW, 32'h7FFF_FFFF);
        write_reg(CFG_HIGH, 32'h8000_0000);
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          a = $signed($urandom()) >>> $urandom_range(4, 20);
          c = a + $urandom_range(1, 1 << 18);
        end
        write_reg(CFG_LOW, ($urandom_range(0, 7) == 0) ? c : ((a < c) ? a : c));
        write_reg(CFG_HIGH, (a < c) ? c : a);
      end
      send_request(REQ_START, $urandom(), 8'($urandom()));
      sent++;
      nsamp = $urandom_range(0, 4);
      for (int i = 0; i < nsamp; i++) begin
        send_request(REQ_RANGE, $urandom() >> $urandom_range(0, 31), '0);
        sent++;
      end
      send_request(REQ_FINISH, $urandom(), 8'($urandom()));
      sent++;
      nsamp = $urandom_range(5, 40);
      for (int i = 0; i < nsamp; i++) begin
        roll = $urandom_range(0, 19);
        if (roll < 13)
          send_request(REQ_BIN, pick_value(range_lo[31:0], range_hi[31:0]), 8'($urandom()));
        else if (roll < 18) send_request(REQ_READ, $urandom(), 8'($urandom()));
        else send_request(3'($urandom_range(1, 7)), $urandom(), 8'($urandom()));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  task automatic test_idle_pause();
    send_request(REQ_BIN, 32'h0000_1000, '0);
    // Hold off until every outstanding result has arrived.
    while (pending_rsp.size() != 0) @(posedge clk);
    send_request(REQ_READ, '0, 8'd0);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      hist_count[i] = '0;
      hist_valid[i] = 1'b0;
    end
    nbins_reg = 9'd256;
    cfg_lo = 64'sd2147483647;
    cfg_hi = -64'sd2147483648;
    range_lo = cfg_lo;
    range_hi = cfg_hi;
    binned_total = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_pause();
    test_random_sessions(1920);
    drain_results();
    $display("covered %0d requests and %0d results over fixed and automatic ranges",
             req_count, rsp_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/arh_pkg.sv
design/arh_divider.sv
design/arh_bin_ram.sv
design/auto_range_histogram_core.sv
bench/tb.sv
